// ----- rtl/ibt_pkg.sv -----
package ibt_pkg;

  localparam int CAPACITY  = 1024;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int STAT_W    = 2;

  typedef enum logic [STAT_W-1:0] {
    STAT_BOOKED   = 2'd0,
    STAT_CONFLICT = 2'd1,
    STAT_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] slot_start;
    logic [TIME_BITS-1:0] slot_finish;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entry_count;
  } out_word_t;

  // one stored interval
  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] finish;
  } entry_t;

endpackage

// ----- rtl/interval_booking_table_core.sv -----
// Interval booking table: holds up to ibt_pkg::CAPACITY non-overlapping half-open
// intervals [start, finish) sorted by start, in one single-port-write, one-read
// synchronous memory. Each input word is a request; each request yields exactly
// one output word with the status (booked, conflict, full) and the number of
// stored intervals afterwards. Requests are handled one at a time. A request
// runs a binary search of at most ceil(log2(n+1)) steps, n being the stored
// count (one memory read and one compare each), then neighbor checks and a
// decide state. When booked, a shift state moves later entries up by one (one
// entry per cycle, read and write overlapped) before an insert state. A done
// state hands the result to the output register once it is free, and the idle
// state takes the next request. A finished result waits in the output register
// while the next request is already accepted. There is no clearing pass:
// entries are only used below the stored count.
module interval_booking_table_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ibt_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output ibt_pkg::out_word_t out_word
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PRED_CMP,
    S_SUCC_RD,
    S_SUCC_CMP,
    S_DECIDE,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } state_t;

  // interval storage
  ibt_pkg::entry_t mem [ibt_pkg::CAPACITY];
  ibt_pkg::entry_t rdata_r;

  state_t state_r, state_nxt;

  logic [ibt_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;       // stored count
  logic [ibt_pkg::CNT_W-1:0]     lo_r, lo_nxt;         // search bounds
  logic [ibt_pkg::CNT_W-1:0]     hi_r, hi_nxt;
  logic [ibt_pkg::TIME_BITS-1:0] key_s_r, key_s_nxt;   // request being served
  logic [ibt_pkg::TIME_BITS-1:0] key_f_r, key_f_nxt;
  logic [ibt_pkg::IDX_W-1:0]     sh_rd_r, sh_rd_nxt;   // next entry to move
  logic [ibt_pkg::CNT_W-1:0]     sh_left_r, sh_left_nxt;
  logic                          wr_pend_r, wr_pend_nxt;
  logic [ibt_pkg::IDX_W-1:0]     wr_addr_r, wr_addr_nxt;
  ibt_pkg::status_t              stat_r, stat_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ibt_pkg::out_word_t            out_word_r, out_word_nxt;

  logic [ibt_pkg::CNT_W-1:0] mid;
  logic [ibt_pkg::CNT_W-1:0] pos_m1;
  logic [ibt_pkg::CNT_W-1:0] cnt_m1;
  logic [ibt_pkg::IDX_W-1:0] rd_addr;
  logic                      mem_we;
  logic [ibt_pkg::IDX_W-1:0] mem_waddr;
  ibt_pkg::entry_t           mem_wdata;
  logic                      in_acc;
  logic                      out_free;

  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign pos_m1 = lo_r - ibt_pkg::CNT_W'(1);
  assign cnt_m1 = cnt_r - ibt_pkg::CNT_W'(1);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    key_s_nxt     = key_s_r;
    key_f_nxt     = key_f_r;
    sh_rd_nxt     = sh_rd_r;
    sh_left_nxt   = sh_left_r;
    wr_pend_nxt   = wr_pend_r;
    wr_addr_nxt   = wr_addr_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    rd_addr       = mid[ibt_pkg::IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = wr_addr_r;
    mem_wdata     = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_s_nxt = in_word.slot_start;
          key_f_nxt = in_word.slot_finish;
          lo_nxt    = '0;
          hi_nxt    = cnt_r;
          // empty or inverted interval never fits
          if (in_word.slot_finish <= in_word.slot_start) begin
            stat_nxt  = ibt_pkg::STAT_CONFLICT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid[ibt_pkg::IDX_W-1:0];
          state_nxt = S_SRCH_CMP;
        end else if (lo_r != '0) begin
          // lo is now the insert position; fetch predecessor
          rd_addr   = pos_m1[ibt_pkg::IDX_W-1:0];
          state_nxt = S_PRED_CMP;
        end else begin
          state_nxt = S_SUCC_RD;
        end
      end
      S_SRCH_CMP: begin
        if (rdata_r.start < key_s_r) begin
          lo_nxt = mid + ibt_pkg::CNT_W'(1);
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH_RD;
      end
      S_PRED_CMP: begin
        if (rdata_r.finish > key_s_r) begin
          stat_nxt  = ibt_pkg::STAT_CONFLICT;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SUCC_RD;
        end
      end
      S_SUCC_RD: begin
        rd_addr = lo_r[ibt_pkg::IDX_W-1:0];
        if (lo_r < cnt_r) begin
          state_nxt = S_SUCC_CMP;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_SUCC_CMP: begin
        if (rdata_r.start < key_f_r) begin
          stat_nxt  = ibt_pkg::STAT_CONFLICT;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (cnt_r == ibt_pkg::CNT_W'(ibt_pkg::CAPACITY)) begin
          stat_nxt  = ibt_pkg::STAT_FULL;
          state_nxt = S_DONE;
        end else begin
          sh_rd_nxt   = cnt_m1[ibt_pkg::IDX_W-1:0];
          sh_left_nxt = cnt_r - lo_r;
          wr_pend_nxt = 1'b0;
          state_nxt   = S_SHIFT;
        end
      end
      S_SHIFT: begin
        // write of entry read last cycle overlaps the next read
        mem_we    = wr_pend_r;
        mem_waddr = wr_addr_r;
        mem_wdata = rdata_r;
        rd_addr   = sh_rd_r;
        if (sh_left_r != '0) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = sh_rd_r + ibt_pkg::IDX_W'(1);
          sh_rd_nxt   = sh_rd_r - ibt_pkg::IDX_W'(1);
          sh_left_nxt = sh_left_r - ibt_pkg::CNT_W'(1);
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            state_nxt = S_INSERT;
          end
        end
      end
      S_INSERT: begin
        mem_we           = 1'b1;
        mem_waddr        = lo_r[ibt_pkg::IDX_W-1:0];
        mem_wdata.start  = key_s_r;
        mem_wdata.finish = key_f_r;
        cnt_nxt          = cnt_r + ibt_pkg::CNT_W'(1);
        stat_nxt         = ibt_pkg::STAT_BOOKED;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        // hand the result word to the output register once it is free
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.status      = stat_r;
          out_word_nxt.entry_count = cnt_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    key_s_r    <= key_s_nxt;
    key_f_r    <= key_f_nxt;
    sh_rd_r    <= sh_rd_nxt;
    sh_left_r  <= sh_left_nxt;
    wr_addr_r  <= wr_addr_nxt;
    stat_r     <= stat_nxt;
    out_word_r <= out_word_nxt;
  end

  // interval memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  // stored count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ibt_pkg::CNT_W'(ibt_pkg::CAPACITY))
    else $error("stored count above capacity");

  // count only ever steps up by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cnt_r) |-> (cnt_r == $past(cnt_r) + ibt_pkg::CNT_W'(1)))
    else $error("stored count changed by other than one");

  // overlapped shift never reads the entry it writes
  a_shift_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wr_pend_r && sh_left_r != '0) |-> (wr_addr_r != sh_rd_r))
    else $error("shift read and write collide");

  // a booked result always reports a nonempty table
  a_booked_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status == ibt_pkg::STAT_BOOKED) |->
      (out_word_r.entry_count != '0))
    else $error("booked with empty table");
`endif

endmodule
